// ----- rtl/tpa_pkg.sv -----
`timescale 1ns / 1ps
package tpa_pkg;

  localparam int ACC_W = 16;
  localparam int SPD_W = 13;
  localparam int TGT_W = 20;
  localparam int POS_W = 21;
  localparam int CMD_W = 17;
  localparam int IDX_W = 3;
  localparam int CFG_DATA_W = 20;

  // Divider: signed dividend, unsigned divisor, truncating quotient
  localparam int DVD_W = 39;
  localparam int MAG_W = DVD_W - 1;
  localparam int DVS_W = 18;
  localparam int CNT_W = $clog2(MAG_W + 1);
  localparam int CMP_W = DVD_W + 1;

  localparam logic [IDX_W-1:0] REG_ACC_RISE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_ACC_FALL   = 3'd1;
  localparam logic [IDX_W-1:0] REG_START_SPD  = 3'd2;
  localparam logic [IDX_W-1:0] REG_END_SPD    = 3'd3;
  localparam logic [IDX_W-1:0] REG_PEAK_SPD   = 3'd4;
  localparam logic [IDX_W-1:0] REG_TARGET     = 3'd5;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    speed_negative;
    logic                    turn_rate_negative;
  } in_beat_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] accel_cmd;
    logic                    done_res;
    logic [SPD_W-1:0]        speed_override;
  } out_beat_t;

  typedef struct packed {
    logic [ACC_W-1:0] acc_rise;
    logic [ACC_W-1:0] acc_fall;
    logic [SPD_W-1:0] start_speed;
    logic [SPD_W-1:0] end_speed;
    logic [SPD_W-1:0] peak_speed;
    logic [TGT_W-1:0] target_position;
  } cfg_t;

  typedef enum logic [1:0] {
    CLS_UP,
    CLS_ZERO,
    CLS_DOWN,
    CLS_DONE
  } cls_t;

  typedef enum logic [1:0] {
    CALC_RUN,
    CALC_XUP,
    CALC_XDN,
    CALC_TRI
  } calc_state_t;

  typedef struct packed {
    logic start;
    logic abort;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ----- rtl/tpa_div.sv -----
`timescale 1ns / 1ps
module tpa_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tpa_pkg::div_ctl_t                  ctl,
  input  logic signed [tpa_pkg::DVD_W-1:0]   dividend,
  input  logic [tpa_pkg::DVS_W-1:0]          divisor,
  output tpa_pkg::div_sts_t                  sts,
  output logic signed [tpa_pkg::DVD_W-1:0]   quotient
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [tpa_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [tpa_pkg::MAG_W-1:0]     q_r, q_nxt;
  logic [tpa_pkg::DVS_W:0]       rem_r, rem_nxt;
  logic [tpa_pkg::DVS_W-1:0]     dvs_r, dvs_nxt;
  logic                          neg_r, neg_nxt;
  logic [tpa_pkg::DVS_W:0]       shifted;
  logic [tpa_pkg::DVD_W-1:0]     abs_dvd;

  assign abs_dvd = dividend[tpa_pkg::DVD_W-1] ? -dividend : dividend;
  assign shifted = {rem_r[tpa_pkg::DVS_W-1:0], q_r[tpa_pkg::MAG_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (ctl.abort) begin
      busy_nxt = 1'b0;
    end else if (ctl.start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = abs_dvd[tpa_pkg::MAG_W-1:0];
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      neg_nxt  = dividend[tpa_pkg::DVD_W-1];
    end else if (busy_r) begin
      // one quotient bit per cycle, restoring
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = shifted - {1'b0, dvs_r};
        q_nxt   = {q_r[tpa_pkg::MAG_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[tpa_pkg::MAG_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == tpa_pkg::CNT_W'(tpa_pkg::MAG_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

endmodule

// ----- rtl/tpa_front.sv -----
`timescale 1ns / 1ps
module tpa_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tpa_pkg::IDX_W-1:0]         cfg_index,
  input  logic [tpa_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tpa_pkg::in_beat_t                 in_data,
  input  logic                              q_full,
  output logic                              push,
  output tpa_pkg::cls_t                     push_cls,
  output tpa_pkg::cfg_t                     cfg
);

  tpa_pkg::cfg_t                      cfg_r, cfg_nxt;
  tpa_pkg::calc_state_t               state_r, state_nxt;
  logic signed [tpa_pkg::DVD_W-1:0]   xup_r, xdn_r, tri_r;
  tpa_pkg::div_ctl_t                  dctl;
  tpa_pkg::div_sts_t                  dsts;
  logic signed [tpa_pkg::DVD_W-1:0]   dvd, quot;
  logic [tpa_pkg::DVS_W-1:0]          dvs;
  logic [tpa_pkg::ACC_W-1:0]          upd, dnd;
  logic [2*tpa_pkg::SPD_W-1:0]        vp2, vs2, ve2;
  logic [tpa_pkg::ACC_W+tpa_pkg::TGT_W-1:0] dn_tar;
  logic signed [tpa_pkg::CMP_W-1:0]   pos_x, tar_x, sum_x, lim_x;
  logic                               cruise, done;
  tpa_pkg::cls_t                      cls;

  // ---- configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        tpa_pkg::REG_ACC_RISE:   cfg_nxt.acc_rise = cfg_data[tpa_pkg::ACC_W-1:0];
        tpa_pkg::REG_ACC_FALL:   cfg_nxt.acc_fall = cfg_data[tpa_pkg::ACC_W-1:0];
        tpa_pkg::REG_START_SPD:  cfg_nxt.start_speed = cfg_data[tpa_pkg::SPD_W-1:0];
        tpa_pkg::REG_END_SPD:    cfg_nxt.end_speed = cfg_data[tpa_pkg::SPD_W-1:0];
        tpa_pkg::REG_PEAK_SPD:   cfg_nxt.peak_speed = cfg_data[tpa_pkg::SPD_W-1:0];
        tpa_pkg::REG_TARGET:     cfg_nxt.target_position = cfg_data[tpa_pkg::TGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.acc_rise        <= tpa_pkg::ACC_W'(4000);
      cfg_r.acc_fall        <= tpa_pkg::ACC_W'(4000);
      cfg_r.start_speed     <= '0;
      cfg_r.end_speed       <= '0;
      cfg_r.peak_speed      <= tpa_pkg::SPD_W'(1000);
      cfg_r.target_position <= '0;
      state_r               <= tpa_pkg::CALC_XUP;
    end else begin
      cfg_r   <= cfg_nxt;
      state_r <= state_nxt;
    end
  end

  assign cfg = cfg_r;

  // ---- threshold sequencer: x_up, x_down, crossover through one divider
  always_comb begin
    state_nxt = state_r;
    if (cfg_we) begin
      state_nxt = tpa_pkg::CALC_XUP;
    end else begin
      unique case (state_r)
        tpa_pkg::CALC_XUP: if (dsts.done) state_nxt = tpa_pkg::CALC_XDN;
        tpa_pkg::CALC_XDN: if (dsts.done) state_nxt = tpa_pkg::CALC_TRI;
        tpa_pkg::CALC_TRI: if (dsts.done) state_nxt = tpa_pkg::CALC_RUN;
        tpa_pkg::CALC_RUN: state_nxt = tpa_pkg::CALC_RUN;
        default:           state_nxt = tpa_pkg::CALC_XUP;
      endcase
    end
  end

  assign upd    = (cfg_r.acc_rise == '0) ? tpa_pkg::ACC_W'(1) : cfg_r.acc_rise;
  assign dnd    = (cfg_r.acc_fall == '0) ? tpa_pkg::ACC_W'(1) : cfg_r.acc_fall;
  assign vp2    = cfg_r.peak_speed * cfg_r.peak_speed;
  assign vs2    = cfg_r.start_speed * cfg_r.start_speed;
  assign ve2    = cfg_r.end_speed * cfg_r.end_speed;
  assign dn_tar = dnd * cfg_r.target_position;

  always_comb begin
    dctl.start = 1'b0;
    dctl.abort = cfg_we;
    in_ready   = 1'b0;
    dvd        = '0;
    dvs        = tpa_pkg::DVS_W'(1);
    unique case (state_r)
      tpa_pkg::CALC_XUP: begin
        dctl.start = !dsts.busy && !dsts.done && !cfg_we;
        dvd = tpa_pkg::DVD_W'(vp2) - tpa_pkg::DVD_W'(vs2);
        dvs = {tpa_pkg::DVS_W'(upd) << 1};
      end
      tpa_pkg::CALC_XDN: begin
        dctl.start = !dsts.busy && !dsts.done && !cfg_we;
        dvd = tpa_pkg::DVD_W'(vp2) - tpa_pkg::DVD_W'(ve2);
        dvs = {tpa_pkg::DVS_W'(dnd) << 1};
      end
      tpa_pkg::CALC_TRI: begin
        dctl.start = !dsts.busy && !dsts.done && !cfg_we;
        dvd = (tpa_pkg::DVD_W'(dn_tar) << 1) + tpa_pkg::DVD_W'(ve2)
              - tpa_pkg::DVD_W'(vs2);
        dvs = (tpa_pkg::DVS_W'(upd) + tpa_pkg::DVS_W'(dnd)) << 1;
      end
      tpa_pkg::CALC_RUN: in_ready = !q_full;
      default: ;
    endcase
  end

  tpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (dctl),
    .dividend (dvd),
    .divisor  (dvs),
    .sts      (dsts),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (dsts.done && state_r == tpa_pkg::CALC_XUP) xup_r <= quot;
    if (dsts.done && state_r == tpa_pkg::CALC_XDN) xdn_r <= quot;
    if (dsts.done && state_r == tpa_pkg::CALC_TRI) tri_r <= quot;
  end

  // ---- classify one position
  assign pos_x  = tpa_pkg::CMP_W'(in_data.position);
  assign tar_x  = $signed({{(tpa_pkg::CMP_W-tpa_pkg::TGT_W){1'b0}}, cfg_r.target_position});
  assign sum_x  = tpa_pkg::CMP_W'(xup_r) + tpa_pkg::CMP_W'(xdn_r);
  assign lim_x  = tar_x - tpa_pkg::CMP_W'(xdn_r);
  assign cruise = tar_x >= sum_x;
  assign done   = (pos_x >= tar_x) || in_data.speed_negative || in_data.turn_rate_negative;

  always_comb begin
    cls = tpa_pkg::CLS_ZERO;
    if (done) begin
      cls = tpa_pkg::CLS_DONE;
    end else if (cruise) begin
      if (pos_x < tpa_pkg::CMP_W'(xup_r)) cls = tpa_pkg::CLS_UP;
      else if (pos_x <= lim_x)           cls = tpa_pkg::CLS_ZERO;
      else                               cls = tpa_pkg::CLS_DOWN;
    end else begin
      if (pos_x < tpa_pkg::CMP_W'(tri_r)) cls = tpa_pkg::CLS_UP;
      else                               cls = tpa_pkg::CLS_DOWN;
    end
  end

  assign push     = in_valid && in_ready;
  assign push_cls = cls;

endmodule

// ----- rtl/tpa_queue.sv -----
`timescale 1ns / 1ps
module tpa_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tpa_pkg::cls_t push_cls,
  input  logic          pop,
  output logic          full,
  output logic          nonempty,
  output tpa_pkg::cls_t head
);

  tpa_pkg::cls_t mem_r [2];
  logic          wp_r, wp_nxt;
  logic          rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  assign full     = cnt_r == 2'd2;
  assign nonempty = cnt_r != 2'd0;
  assign head     = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= push_cls;
  end

endmodule

// ----- rtl/tpa_back.sv -----
`timescale 1ns / 1ps
module tpa_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               nonempty,
  input  tpa_pkg::cls_t      head,
  output logic               pop,
  input  tpa_pkg::cfg_t      cfg,
  output logic               out_valid,
  input  logic               out_ready,
  output tpa_pkg::out_beat_t out_data
);

  logic               vld_r, vld_nxt;
  tpa_pkg::out_beat_t dat_r, dat_nxt;

  assign pop = nonempty && (!vld_r || out_ready);

  always_comb begin
    vld_nxt = vld_r;
    dat_nxt = dat_r;
    if (out_ready) vld_nxt = 1'b0;
    if (pop) begin
      vld_nxt = 1'b1;
      dat_nxt.done_res       = 1'b0;
      dat_nxt.speed_override = '0;
      case (head)
        tpa_pkg::CLS_UP:   dat_nxt.accel_cmd = $signed({1'b0, cfg.acc_rise});
        tpa_pkg::CLS_DOWN: dat_nxt.accel_cmd = -$signed({1'b0, cfg.acc_fall});
        tpa_pkg::CLS_DONE: begin
          dat_nxt.accel_cmd      = '0;
          dat_nxt.done_res       = 1'b1;
          dat_nxt.speed_override = cfg.end_speed;
        end
        default:           dat_nxt.accel_cmd = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= vld_nxt;
    dat_r <= dat_nxt;
  end

  assign out_valid = vld_r;
  assign out_data  = dat_r;

endmodule

// ----- rtl/trapezoidal_profile_accel.sv -----
`timescale 1ns / 1ps
// Trapezoidal velocity profile: one acceleration command per control tick.
// Input channel (in_valid/in_ready/in_data) carries one beat per tick: the
//   travelled position and the two velocity sign flags.
// Output channel (out_valid/out_ready/out_data) returns one beat per input
//   beat, in order: accel_cmd (+up, 0, -down), done_res, speed_override.
// Config port (cfg_we/cfg_index/cfg_data) writes the register selected by cfg_index.
// Ramp distances and the crossover point depend on config only. They are
//   computed by one serial divider, one quotient bit per cycle: three divides
//   of 38 steps plus handoff, after reset and after every config write.
//   in_ready stays low while they are computed.
// Afterwards one beat is taken every cycle while the queue is not full. After
//   input acceptance the classifier writes a 2-deep queue, and the output
//   register loads from it once free; out_valid then rises.
// When the receiver stalls, the output register holds and the queue fills;
//   in_ready drops once the queue is full. Synchronous reset, active low,
//   restores register defaults and empties the pipeline.
module trapezoidal_profile_accel (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tpa_pkg::IDX_W-1:0]      cfg_index,
  input  logic [tpa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tpa_pkg::in_beat_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tpa_pkg::out_beat_t             out_data
);

  logic          push, pop, q_full, q_nonempty;
  tpa_pkg::cls_t push_cls, head;
  tpa_pkg::cfg_t cfg;

  // front: config, thresholds, classification
  tpa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_cls  (push_cls),
    .cfg       (cfg)
  );

  // decouples the classifier from output stalls
  tpa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cls (push_cls),
    .pop      (pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (head)
  );

  // back: builds the result beat
  tpa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .nonempty  (q_nonempty),
    .head      (head),
    .pop       (pop),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // done beats command zero and return the end speed
  a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |->
      out_data.accel_cmd == '0 && out_data.speed_override == cfg.end_speed)
    else $error("done beat with bad fields");

  a_no_override: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.done_res |-> out_data.speed_override == '0)
    else $error("speed override without done");

  // a config write restarts threshold computation
  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input taken with stale thresholds");

endmodule

// ----- dv/tpa_checker.sv -----
`timescale 1ns / 1ps
module tpa_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  tpa_pkg::in_beat_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  tpa_pkg::out_beat_t out_data,
  output int                 fail_count,
  output int                 pending
);

  logic [tpa_pkg::ACC_W-1:0] up_r, dn_r;
  logic [tpa_pkg::SPD_W-1:0] vs_r, ve_r, vp_r;
  logic [tpa_pkg::TGT_W-1:0] tar_r;
  tpa_pkg::out_beat_t accel_q[$];

  assign pending = accel_q.size();

  function automatic tpa_pkg::out_beat_t profile_accel(tpa_pkg::in_beat_t b);
    longint up, dn, vs, ve, vp, tar, pos, upd, dnd, x_up, x_dn, tri_pt, acc;
    logic done;
    tpa_pkg::out_beat_t r;
    up = up_r; dn = dn_r; vs = vs_r; ve = ve_r; vp = vp_r; tar = tar_r;
    pos = longint'(b.position);
    upd = (up == 0) ? 1 : up;
    dnd = (dn == 0) ? 1 : dn;
    x_up = (vp * vp - vs * vs) / (2 * upd);
    x_dn = (vp * vp - ve * ve) / (2 * dnd);
    tri_pt = (2 * dnd * tar + ve * ve - vs * vs) / (2 * (upd + dnd));
    acc = 0;
    if (tar >= x_up + x_dn) begin
      if (pos < x_up) acc = up;
      else if (pos <= tar - x_dn) acc = 0;
      else if (pos <= tar) acc = -dn;
    end else begin
      if (pos < tri_pt) acc = up;
      else if (pos <= tar) acc = -dn;
    end
    done = (pos >= tar) || b.speed_negative || b.turn_rate_negative;
    if (done) acc = 0;
    r.accel_cmd = acc[tpa_pkg::CMD_W-1:0];
    r.done_res = done;
    r.speed_override = done ? ve_r : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    tpa_pkg::out_beat_t exp_b;
    if (!rst_n) begin
      up_r <= 16'd4000; dn_r <= 16'd4000;
      vs_r <= '0; ve_r <= '0; vp_r <= 13'd1000; tar_r <= '0;
      accel_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tpa_pkg::REG_ACC_RISE:  up_r <= cfg_data[tpa_pkg::ACC_W-1:0];
          tpa_pkg::REG_ACC_FALL:  dn_r <= cfg_data[tpa_pkg::ACC_W-1:0];
          tpa_pkg::REG_START_SPD: vs_r <= cfg_data[tpa_pkg::SPD_W-1:0];
          tpa_pkg::REG_END_SPD:   ve_r <= cfg_data[tpa_pkg::SPD_W-1:0];
          tpa_pkg::REG_PEAK_SPD:  vp_r <= cfg_data[tpa_pkg::SPD_W-1:0];
          tpa_pkg::REG_TARGET:    tar_r <= cfg_data[tpa_pkg::TGT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) accel_q.push_back(profile_accel(in_data));
      if (out_valid && out_ready) begin
        if (accel_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_b = accel_q.pop_front();
          if (exp_b !== out_data) begin
            $display("%0t: mismatch expected cmd=%0d done=%b ovr=%0d",
                     $time, exp_b.accel_cmd, exp_b.done_res, exp_b.speed_override);
            $display("%0t:          actual   cmd=%0d done=%b ovr=%0d",
                     $time, out_data.accel_cmd, out_data.done_res,
                     out_data.speed_override);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  // index past the end of the register list
  localparam logic [tpa_pkg::IDX_W-1:0] REG_UNMAPPED = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [tpa_pkg::IDX_W-1:0] cfg_index = '0;
  logic [tpa_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  tpa_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tpa_pkg::out_beat_t out_data;
  int fail_count, pending;
  bit quiet_tail = 1'b0;  // no idling near the end of the run

  // 12 ns period
  always #6 clk = ~clk;

  trapezoidal_profile_accel dut (.*);

  tpa_checker chk (.*);

  // Receiver: random stall bursts, or always ready in the quiet tail.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 12);
        repeat (n - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Register write; only issued with the block idle. Caller drops cfg_we.
  task automatic write_reg(input logic [tpa_pkg::IDX_W-1:0] idx,
                           input logic [tpa_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // Drains every expected beat, then a margin so the block is idle.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One beat, held until accepted; optional random gap before it.
  // valid stays up afterwards so back-to-back beats need no gap.
  task automatic send_position(input logic signed [tpa_pkg::POS_W-1:0] pos, input logic sv,
                               input logic sw, input bit may_idle);
    int n;
    if (may_idle && !quiet_tail && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{position: pos, speed_negative: sv, turn_rate_negative: sw};
    do @(posedge clk); while (!in_ready);
  endtask

  // Mix of positions near the target, from zero to just past it, plus full-range noise.
  task automatic random_burst(input int count, input logic [tpa_pkg::TGT_W-1:0] tar);
    logic signed [tpa_pkg::POS_W-1:0] p;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 4))
        0: p = tpa_pkg::POS_W'($urandom);                 // any 21-bit value
        1: p = tpa_pkg::POS_W'($signed({1'b0, tar}) + $signed($urandom_range(0, 8)) - 4);
        default: p = tpa_pkg::POS_W'($urandom_range(0, tar + 16));
      endcase
      send_position(p, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0, 1'b1);
    end
  endtask

  task automatic load_cfg(input int u, input int d, input int vs, input int ve,
                          input int vp, input int tar);
    write_reg(tpa_pkg::REG_ACC_RISE, tpa_pkg::CFG_DATA_W'(u));
    write_reg(tpa_pkg::REG_ACC_FALL, tpa_pkg::CFG_DATA_W'(d));
    write_reg(tpa_pkg::REG_START_SPD, tpa_pkg::CFG_DATA_W'(vs));
    write_reg(tpa_pkg::REG_END_SPD, tpa_pkg::CFG_DATA_W'(ve));
    write_reg(tpa_pkg::REG_PEAK_SPD, tpa_pkg::CFG_DATA_W'(vp));
    write_reg(tpa_pkg::REG_TARGET, tpa_pkg::CFG_DATA_W'(tar));
    write_reg(REG_UNMAPPED, tpa_pkg::CFG_DATA_W'($urandom));  // must be ignored
    cfg_we <= 1'b0;
  endtask

  initial begin
    int tar_v;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset config (target 0, a done beat and one below target)
    send_position(21'sd0, 1'b0, 1'b0, 1'b0);
    send_position(-21'sd1, 1'b0, 1'b0, 1'b0);
    drain();

    // Cruise profile: x_up = 125, x_down = 113
    load_cfg(4000, 4000, 0, 300, 1000, 1000);
    send_position(21'sh100000, 1'b0, 1'b0, 1'b0);  // most negative
    send_position(21'sd0, 1'b0, 1'b0, 1'b0);
    send_position(21'sd124, 1'b0, 1'b0, 1'b0);
    send_position(21'sd125, 1'b0, 1'b0, 1'b0);
    send_position(21'sd900, 1'b0, 1'b0, 1'b0);
    send_position(21'sd950, 1'b0, 1'b0, 1'b0);
    send_position(21'sd999, 1'b0, 1'b0, 1'b0);
    send_position(21'sd1000, 1'b0, 1'b0, 1'b0);
    send_position(21'sh0FFFFF, 1'b0, 1'b0, 1'b0);  // most positive
    send_position(21'sd10, 1'b1, 1'b0, 1'b0);
    send_position(21'sd10, 1'b0, 1'b1, 1'b0);
    send_position(21'sd10, 1'b1, 1'b1, 1'b0);
    drain();

    // Profile with zero accelerations and speeds above peak
    load_cfg(0, 0, 8191, 8191, 0, 1048575);
    send_position(21'sd0, 1'b0, 1'b0, 1'b0);
    send_position(21'sd524287, 1'b0, 1'b0, 1'b0);
    send_position(21'sd1048574, 1'b0, 1'b0, 1'b0);
    drain();

    // Extremes: max accelerations, max peak
    load_cfg(65535, 65535, 0, 8191, 8191, 1048575);
    send_position(21'sd100, 1'b0, 1'b0, 1'b0);
    send_position(21'sd1048000, 1'b0, 1'b0, 1'b0);
    drain();

    // Random phases, each with a random configuration
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) quiet_tail = 1'b1;
      tar_v = (ph % 2) ? $urandom_range(0, 1048575) : $urandom_range(0, 4000);
      load_cfg($urandom_range(0, 65535), $urandom_range(0, 65535),
               $urandom_range(0, 8191), $urandom_range(0, 8191),
               $urandom_range(0, 8191), tar_v);
      random_burst(50, tpa_pkg::TGT_W'(tar_v));
      drain();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule

// ----- trapezoidal_profile_accel.f -----
rtl/tpa_pkg.sv
rtl/tpa_div.sv
rtl/tpa_front.sv
rtl/tpa_queue.sv
rtl/tpa_back.sv
rtl/trapezoidal_profile_accel.sv
dv/tpa_checker.sv
dv/testbench.sv
